>>> hw/rtl/wpuv_pkg.sv
// Shared constants, tables and types of the wind polar to u/v converter.
package wpuv_pkg;

    localparam int FRAC_BITS       = 8;
    localparam int ROTATION_STAGES = 16;
    localparam int ATAN_LEN        = 24;
    localparam int CORDIC_STAGES   = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;

    localparam int CODE_W = 16;
    localparam int XY_W   = 34;
    localparam int Z_W    = 32;
    localparam int PROD_W = XY_W + CODE_W;
    localparam int NEG_W  = PROD_W + 1;
    localparam int OUT_W  = 25;
    localparam int RND_SH = 30 - FRAC_BITS;

    localparam logic [11:0] DIR_MOD      = 12'd3600;
    localparam logic [10:0] MOD_RECIP    = 11'd1165;
    localparam int          MOD_RECIP_SH = 22;
    localparam logic [20:0] TURN_WHOLE   = 21'd1193046;
    localparam logic [10:0] TURN_REM     = 11'd1696;
    localparam logic [10:0] TURN_HALF    = 11'd1800;
    localparam logic [22:0] DIV_RECIP    = 23'd4772186;
    localparam int          DIV_RECIP_SH = 34;
    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic signed [CODE_W-1:0] MISSING_LIMIT = -16'sd9000;
    localparam logic signed [CODE_W-1:0] DIV_MISSING   = 16'sd32767;

    localparam logic signed [NEG_W-1:0] OUT_MAX = NEG_W'(16777215);
    localparam logic signed [NEG_W-1:0] OUT_MIN = -NEG_W'(16777216);
    localparam logic signed [NEG_W-1:0] RND_ADD = NEG_W'(1) <<< (RND_SH - 1);

    localparam logic [29:0] ATAN_TURNS [ATAN_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } t_quad;

    typedef struct packed {
        logic signed [CODE_W-1:0] speed;
        logic                     dir_ok;
        logic signed [CODE_W-1:0] vert;
        logic                     vert_ok;
        logic signed [CODE_W-1:0] refl;
        logic                     refl_ok;
        logic signed [CODE_W-1:0] divg;
        logic                     divg_ok;
        t_quad                    quad;
    } t_side;

endpackage

>>> hw/rtl/wpuv_phase.sv
// Direction reduction modulo 3600, turn phase and quadrant split, five register stages.
module wpuv_phase
    import wpuv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [CODE_W-1:0] i_dir,
    input  logic signed [CODE_W-1:0] i_speed,
    input  logic signed [CODE_W-1:0] i_vert,
    input  logic signed [CODE_W-1:0] i_refl,
    input  logic signed [CODE_W-1:0] i_divg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [Z_W-1:0]    o_z,
    output t_side                    o_side
);

    localparam int NST = 5;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_rdy;
    t_side          r_side [NST];
    t_side          n_side;
    t_side          n_side4;

    logic [14:0]    r_dir1;
    logic [3:0]     r_quo1;
    logic [11:0]    r_d2;
    logic [22:0]    r_n3;
    logic [31:0]    r_base3, r_base4;
    logic [10:0]    r_frac4;
    logic signed [Z_W-1:0] r_z5;

    logic [25:0]    w_mprod;
    logic [15:0]    w_rem;
    logic [11:0]    n_d2;
    logic [45:0]    w_dprod;
    logic [31:0]    w_phase, w_shift;

    always_comb begin
        w_rdy[NST] = i_ready;
        for (int k = 0; k < NST; k++) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0] && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_side.speed   = i_speed;
        n_side.dir_ok  = !i_dir[CODE_W-1];
        n_side.vert    = i_vert;
        n_side.vert_ok = i_vert > MISSING_LIMIT;
        n_side.refl    = i_refl;
        n_side.refl_ok = i_refl > MISSING_LIMIT;
        n_side.divg    = i_divg;
        n_side.divg_ok = i_divg < DIV_MISSING;
        n_side.quad    = QUAD_0;
    end

    assign w_mprod = 26'(i_dir[14:0]) * 26'(MOD_RECIP);
    assign w_rem   = {1'b0, r_dir1} - 16'(r_quo1) * 16'(DIR_MOD);
    assign n_d2    = (w_rem >= 16'(DIR_MOD)) ? 12'(w_rem - 16'(DIR_MOD)) : w_rem[11:0];
    assign w_dprod = 46'(r_n3) * 46'(DIV_RECIP);
    assign w_phase = r_base4 + 32'(r_frac4);
    assign w_shift = w_phase + EIGHTH_TURN;

    always_comb begin
        n_side4      = r_side[3];
        n_side4.quad = t_quad'(w_shift[31:30]);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_side[0] <= n_side;
            r_dir1    <= i_dir[14:0];
            r_quo1    <= w_mprod[MOD_RECIP_SH+3:MOD_RECIP_SH];
        end
        if (w_rdy[1]) begin
            r_side[1] <= r_side[0];
            r_d2      <= n_d2;
        end
        if (w_rdy[2]) begin
            r_side[2] <= r_side[1];
            r_n3      <= 23'(r_d2) * 23'(TURN_REM) + 23'(TURN_HALF);
            r_base3   <= 32'(r_d2) * 32'(TURN_WHOLE);
        end
        if (w_rdy[3]) begin
            r_side[3] <= r_side[2];
            r_base4   <= r_base3;
            r_frac4   <= w_dprod[DIV_RECIP_SH+10:DIV_RECIP_SH];
        end
        if (w_rdy[4]) begin
            r_side[4] <= n_side4;
            r_z5      <= $signed(w_phase - {w_shift[31:30], 30'b0});
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_z     = r_z5;
    assign o_side  = r_side[NST-1];

endmodule

>>> hw/rtl/wpuv_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration.
module wpuv_cordic
    import wpuv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [Z_W-1:0]  i_z,
    input  t_side                  i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output t_side                  o_side
);

    logic [CORDIC_STAGES-1:0] r_vld;
    logic [CORDIC_STAGES:0]   w_rdy;

    logic signed [XY_W-1:0] r_x [CORDIC_STAGES];
    logic signed [XY_W-1:0] r_y [CORDIC_STAGES];
    logic signed [Z_W-1:0]  r_z [CORDIC_STAGES];
    t_side                  r_side [CORDIC_STAGES];

    assign w_rdy[CORDIC_STAGES] = i_ready;
    assign o_ready = w_rdy[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic signed [XY_W-1:0] w_x, w_y;
        logic signed [Z_W-1:0]  w_z, w_a;
        logic                   w_v;
        t_side                  w_s;

        if (k == 0) begin : g_first
            assign w_x = CORDIC_GAIN;
            assign w_y = '0;
            assign w_z = i_z;
            assign w_v = i_valid;
            assign w_s = i_side;
        end else begin : g_next
            assign w_x = r_x[k-1];
            assign w_y = r_y[k-1];
            assign w_z = r_z[k-1];
            assign w_v = r_vld[k-1];
            assign w_s = r_side[k-1];
        end

        assign w_a      = $signed({2'b00, ATAN_TURNS[k]});
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_side[k] <= w_s;
                if (!w_z[Z_W-1]) begin
                    r_x[k] <= w_x - (w_y >>> k);
                    r_y[k] <= w_y + (w_x >>> k);
                    r_z[k] <= w_z - w_a;
                end else begin
                    r_x[k] <= w_x + (w_y >>> k);
                    r_y[k] <= w_y - (w_x >>> k);
                    r_z[k] <= w_z + w_a;
                end
            end
        end
    end

    assign o_valid = r_vld[CORDIC_STAGES-1];
    assign o_x     = r_x[CORDIC_STAGES-1];
    assign o_y     = r_y[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];

endmodule

>>> hw/rtl/wpuv_scale.sv
// Quadrant rotation, speed multiply, rounding and saturation, three register stages.
module wpuv_scale
    import wpuv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  t_side                  i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [OUT_W-1:0] o_east,
    output logic signed [OUT_W-1:0] o_north,
    output t_side                  o_side
);

    localparam int NST = 3;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_rdy;
    t_side          r_side [NST];

    logic signed [XY_W-1:0]   n_cos, n_sin, r_cos, r_sin;
    logic signed [PROD_W-1:0] r_pu, r_pv;
    logic signed [NEG_W-1:0]  w_ru, w_rv, w_su, w_sv;
    logic signed [OUT_W-1:0]  n_east, n_north, r_east, r_north;

    always_comb begin
        w_rdy[NST] = i_ready;
        for (int k = 0; k < NST; k++) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        case (i_side.quad)
            QUAD_0: begin
                n_cos = i_x;
                n_sin = i_y;
            end
            QUAD_90: begin
                n_cos = -i_y;
                n_sin = i_x;
            end
            QUAD_180: begin
                n_cos = -i_x;
                n_sin = -i_y;
            end
            QUAD_270: begin
                n_cos = i_y;
                n_sin = -i_x;
            end
            default: begin
                n_cos = i_x;
                n_sin = i_y;
            end
        endcase
    end

    assign w_ru = -NEG_W'(r_pu) + RND_ADD;
    assign w_rv = -NEG_W'(r_pv) + RND_ADD;
    assign w_su = w_ru >>> RND_SH;
    assign w_sv = w_rv >>> RND_SH;

    always_comb begin
        if (w_su > OUT_MAX) begin
            n_east = OUT_W'(OUT_MAX);
        end else if (w_su < OUT_MIN) begin
            n_east = OUT_W'(OUT_MIN);
        end else begin
            n_east = w_su[OUT_W-1:0];
        end
        if (w_sv > OUT_MAX) begin
            n_north = OUT_W'(OUT_MAX);
        end else if (w_sv < OUT_MIN) begin
            n_north = OUT_W'(OUT_MIN);
        end else begin
            n_north = w_sv[OUT_W-1:0];
        end
        if (!r_side[1].dir_ok) begin
            n_east  = '0;
            n_north = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_side[0] <= i_side;
            r_cos     <= n_cos;
            r_sin     <= n_sin;
        end
        if (w_rdy[1]) begin
            r_side[1] <= r_side[0];
            r_pu      <= PROD_W'(r_sin) * PROD_W'(r_side[0].speed);
            r_pv      <= PROD_W'(r_cos) * PROD_W'(r_side[0].speed);
        end
        if (w_rdy[2]) begin
            r_side[2] <= r_side[1];
            r_east    <= n_east;
            r_north   <= n_north;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_east  = r_east;
    assign o_north = r_north;
    assign o_side  = r_side[NST-1];

endmodule

>>> hw/rtl/wind_polar_to_uv_converter.sv
// Top level of the wind polar to u/v converter with stream input and output.
//
// The slave channel takes one grid sample per word: direction, speed, vertical,
// reflectivity and divergence codes, 16 bits each. The master channel gives one
// result word per sample: the east and north wind components in tenths of m/s
// with FRAC_BITS fraction bits, the wind flag and the three codes with flags.
// A word is moved when tvalid and tready are both high at a rising clock edge.
// Results leave in the order the samples came in.
//
// Five stages reduce the direction and form the turn phase, one CORDIC
// iteration per stage follows, and three stages scale, round and saturate.
// Throughput is one sample per cycle while m_axis_tready stays high.
//
// Every stage holds its word while the next one is full and stalled, and any
// empty stage still takes a word, so the input keeps accepting until the whole
// pipeline is full behind a stalled receiver. Nothing is lost or repeated.
// Reset clears all valid bits and holds s_axis_tready low; the block is ready as soon as reset is released.
module wind_polar_to_uv_converter
    import wpuv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // direction[15:0], speed[31:16], vertical[47:32], reflectivity[63:48],
    // divergence[79:64]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // east[24:0], north[49:25], wind_ok[50], vertical[66:51], vertical_ok[67],
    // reflectivity[83:68], reflectivity_ok[84], divergence[100:85],
    // divergence_ok[101], zero[103:102]
    output logic [103:0] m_axis_tdata
);

    logic                   w_ph_valid, w_ph_ready;
    logic signed [Z_W-1:0]  w_ph_z;
    t_side                  w_ph_side;

    logic                   w_co_valid, w_co_ready;
    logic signed [XY_W-1:0] w_co_x, w_co_y;
    t_side                  w_co_side;

    logic signed [OUT_W-1:0] w_east, w_north;
    t_side                   w_out_side;

    wpuv_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_dir   ($signed(s_axis_tdata[15:0])),
        .i_speed ($signed(s_axis_tdata[31:16])),
        .i_vert  ($signed(s_axis_tdata[47:32])),
        .i_refl  ($signed(s_axis_tdata[63:48])),
        .i_divg  ($signed(s_axis_tdata[79:64])),
        .o_valid (w_ph_valid),
        .i_ready (w_ph_ready),
        .o_z     (w_ph_z),
        .o_side  (w_ph_side)
    );

    wpuv_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ph_valid),
        .o_ready (w_ph_ready),
        .i_z     (w_ph_z),
        .i_side  (w_ph_side),
        .o_valid (w_co_valid),
        .i_ready (w_co_ready),
        .o_x     (w_co_x),
        .o_y     (w_co_y),
        .o_side  (w_co_side)
    );

    wpuv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_co_valid),
        .o_ready (w_co_ready),
        .i_x     (w_co_x),
        .i_y     (w_co_y),
        .i_side  (w_co_side),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_east  (w_east),
        .o_north (w_north),
        .o_side  (w_out_side)
    );

    assign m_axis_tdata = {
        2'b00,
        w_out_side.divg_ok,
        w_out_side.divg,
        w_out_side.refl_ok,
        w_out_side.refl,
        w_out_side.vert_ok,
        w_out_side.vert,
        w_out_side.dir_ok,
        w_north,
        w_east
    };

endmodule

>>> tb/sv/uv_check_pkg.sv
// Scoreboard and sample predictor for the wind polar to u/v converter test.
`timescale 1ns / 1ps

package uv_check_pkg;
    import wpuv_pkg::*;

    localparam int UV_STAGES = (ROTATION_STAGES < 24) ? ROTATION_STAGES : 24;
    localparam longint UV_GAIN = 652032874;
    localparam longint UV_MAX = 16777215;
    localparam longint UV_MIN = -16777216;

    localparam longint TURN_ATAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic [1:0]  pad;
        logic        divg_ok;
        logic [15:0] divg;
        logic        refl_ok;
        logic [15:0] refl;
        logic        vert_ok;
        logic [15:0] vert;
        logic        wind_ok;
        logic [24:0] north;
        logic [24:0] east;
    } t_uv_word;

    function automatic logic [24:0] round_component(longint prod_q30);
        longint r;
        r = (prod_q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (r > UV_MAX) begin
            r = UV_MAX;
        end
        if (r < UV_MIN) begin
            r = UV_MIN;
        end
        return r[24:0];
    endfunction

    function automatic t_uv_word predict_uv(logic [79:0] w);
        logic signed [15:0] dir;
        logic signed [15:0] spd;
        logic signed [15:0] vert;
        logic signed [15:0] refl;
        logic signed [15:0] divg;
        longint unsigned phase64;
        logic [31:0] phase;
        logic [31:0] nudged;
        logic [31:0] res;
        int d;
        int z32;
        t_quad q;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint c;
        longint s;
        t_uv_word r;
        dir  = w[15:0];
        spd  = w[31:16];
        vert = w[47:32];
        refl = w[63:48];
        divg = w[79:64];
        r = '0;
        if (dir >= 0) begin
            d = dir;
            d = d % 3600;
            phase64 = ((longint'(d) << 32) + 64'd1800) / 64'd3600;
            phase = phase64[31:0];
            nudged = phase + 32'h2000_0000;
            q = t_quad'(nudged[31:30]);
            res = phase - {nudged[31:30], 30'd0};
            z32 = res;
            z = z32;
            x = UV_GAIN;
            y = 0;
            for (int i = 0; i < UV_STAGES; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - TURN_ATAN[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + TURN_ATAN[i];
                end
                x = nx;
            end
            case (q)
                QUAD_0: begin
                    c = x;
                    s = y;
                end
                QUAD_90: begin
                    c = -y;
                    s = x;
                end
                QUAD_180: begin
                    c = -x;
                    s = -y;
                end
                default: begin
                    c = y;
                    s = -x;
                end
            endcase
            r.east    = round_component(-(s * longint'(spd)));
            r.north   = round_component(-(c * longint'(spd)));
            r.wind_ok = 1'b1;
        end
        r.vert    = vert;
        r.vert_ok = (vert > -16'sd9000);
        r.refl    = refl;
        r.refl_ok = (refl > -16'sd9000);
        r.divg    = divg;
        r.divg_ok = (divg < 16'sd32767);
        return r;
    endfunction

    class uv_result_board;
        t_uv_word expected_uv[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_sample(logic [79:0] w);
            expected_uv.push_back(predict_uv(w));
        endfunction

        function void check_word(logic [103:0] d);
            t_uv_word act;
            t_uv_word exp_w;
            act = t_uv_word'(d);
            if (expected_uv.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result word %h arrived with no sample pending", d);
                end
                return;
            end
            exp_w = expected_uv.pop_front();
            if (act.east !== exp_w.east || act.north !== exp_w.north
                    || act.wind_ok !== exp_w.wind_ok || act.vert !== exp_w.vert
                    || act.vert_ok !== exp_w.vert_ok || act.refl !== exp_w.refl
                    || act.refl_ok !== exp_w.refl_ok || act.divg !== exp_w.divg
                    || act.divg_ok !== exp_w.divg_ok || act.pad !== exp_w.pad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected u=%0d v=%0d w=%b vert=%0d/%b refl=%0d/%b div=%0d/%b pad=%b",
                             $signed(exp_w.east), $signed(exp_w.north), exp_w.wind_ok,
                             $signed(exp_w.vert), exp_w.vert_ok, $signed(exp_w.refl),
                             exp_w.refl_ok, $signed(exp_w.divg), exp_w.divg_ok, exp_w.pad);
                    $display("          actual   u=%0d v=%0d w=%b vert=%0d/%b refl=%0d/%b div=%0d/%b pad=%b",
                             $signed(act.east), $signed(act.north), act.wind_ok,
                             $signed(act.vert), act.vert_ok, $signed(act.refl),
                             act.refl_ok, $signed(act.divg), act.divg_ok, act.pad);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/sv/wind_polar_to_uv_converter_test.sv
// Top of the stream test bench for the wind polar to u/v converter.
`timescale 1ns / 1ps

module wind_polar_to_uv_converter_test;
    import wpuv_pkg::*;
    import uv_check_pkg::*;

    localparam int RANDOM_SAMPLES = 1230;
    localparam int HOLD_CYCLES    = 160;
    localparam int DRAIN_CYCLES   = 40;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    uv_result_board board = new();
    int  in_idle_pct  = 28;
    int  out_idle_pct = 28;
    bit  hold_request = 1'b0;

    wind_polar_to_uv_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [79:0] pack_sample(int dir, int spd, int vert, int refl, int divg);
        return {16'(divg), 16'(refl), 16'(vert), 16'(spd), 16'(dir)};
    endfunction

    function automatic int pick_code(int limit);
        if ($urandom_range(0, 99) < 20) begin
            return limit - 2 + int'($urandom_range(0, 4));
        end
        return int'($urandom_range(0, 65535));
    endfunction

    function automatic logic [79:0] random_sample();
        int sel;
        int dir;
        int spd;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            dir = $urandom_range(0, 3599);
        end else if (sel < 82) begin
            dir = $urandom_range(3600, 32767);
        end else if (sel < 92) begin
            dir = -int'($urandom_range(1, 32768));
        end else begin
            dir = $urandom_range(0, 65535);
        end
        if ($urandom_range(0, 99) < 60) begin
            spd = $urandom_range(0, 65535);
        end else begin
            spd = int'($urandom_range(0, 1200)) - 600;
        end
        return pack_sample(dir, spd, pick_code(-9000), pick_code(-9000), pick_code(32767));
    endfunction

    task automatic send_sample(input logic [79:0] w);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        board.note_sample(w);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                board.check_word(m_axis_tdata);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= out_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(pack_sample(0, 32767, -9000, -8999, 32767));
        send_sample(pack_sample(900, 32767, -8999, -9000, 32766));
        send_sample(pack_sample(1800, -32768, -9001, -9001, -32768));
        send_sample(pack_sample(2700, -32768, -32768, 32767, 0));
        send_sample(pack_sample(3599, 32767, 32767, -32768, 32767));
        send_sample(pack_sample(3600, 1000, 0, 0, 0));
        send_sample(pack_sample(3601, -1, 1, -1, -1));
        send_sample(pack_sample(7200, 1, 100, 200, 300));
        send_sample(pack_sample(10800, 32767, -9999, -9999, 32767));
        send_sample(pack_sample(32767, 32767, 12345, -12345, 32766));
        send_sample(pack_sample(-1, 32767, 5, 6, 7));
        send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768));
        send_sample(pack_sample(450, 0, -9000, 32767, 32767));
        send_sample(pack_sample(1350, -1, 250, -9000, 1));
        send_sample(pack_sample(2250, 32767, -250, 640, -1));
        send_sample(pack_sample(3150, -32767, 9000, 9000, 32767));
        send_sample(pack_sample(1, 32767, 0, 0, 0));
        send_sample(pack_sample(899, -32768, 0, 0, 0));
        send_sample(pack_sample(1799, 32767, 0, 0, 0));
        send_sample(pack_sample(1801, 32767, 0, 0, 0));
        send_sample(pack_sample(2699, -32768, 0, 0, 0));

        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            if (n == 300) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (n == 450) begin
                hold_request = 1'b1;
            end
            if (n == 700) begin
                in_idle_pct  = 28;
                out_idle_pct = 28;
            end
            send_sample(random_sample());
        end
        s_axis_tvalid <= 1'b0;

        while (board.expected_uv.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_uv.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
